@@ sv/tsp_pkg.sv @@
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types and codes for the trapezoidal step profile generator.
// ----------------------------------------------------------------------------
package tsp_pkg;

    // Command codes carried on the input tuser
    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_MOVE_ABS = 3'd1,
        CMD_MOVE_REL = 3'd2,
        CMD_VEL_RUN  = 3'd3,
        CMD_STOP     = 3'd4
    } t_cmd;

    // Motion phase codes
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ACCEL  = 3'd1,
        PH_CRUISE = 3'd2,
        PH_DECEL  = 3'd3,
        PH_VEL    = 3'd4,
        PH_STOP   = 3'd5
    } t_phase;

    // Configuration register indexes
    localparam logic [1:0] REG_MAX_VELOCITY = 2'd0;
    localparam logic [1:0] REG_ACCEL_RATE   = 2'd1;
    localparam logic [1:0] REG_DECEL_RATE   = 2'd2;

    // Current limits and rates, fixed point steps per tick
    typedef struct packed {
        logic [30:0] max_velocity;
        logic [30:0] accel_rate;
        logic [30:0] decel_rate;
    } t_cfg;

    // One result item
    typedef struct packed {
        t_phase             phase;
        logic               busy_res;
        logic signed [31:0] position;
        logic signed [31:0] step_delta;
    } t_result;

endpackage

@@ sv/tsp_cfg.sv @@
// ----------------------------------------------------------------------------
// tsp_cfg
// Configuration register file: velocity limit and ramp rates.
// ----------------------------------------------------------------------------
module tsp_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [1:0]    i_wr_index,
    input  logic [30:0]   i_wr_data,
    output tsp_pkg::t_cfg o_cfg
);
    import tsp_pkg::*;

    logic [30:0] r_max_velocity;
    logic [30:0] r_accel_rate;
    logic [30:0] r_decel_rate;
    logic [30:0] n_rate;

    // Treat a zero rate as one
    assign n_rate = (i_wr_data == '0) ? 31'd1 : i_wr_data;

    // Write the addressed register; other indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_velocity <= '0;
            r_accel_rate   <= 31'd1;
            r_decel_rate   <= 31'd1;
        end else if (i_wr_en) begin
            case (i_wr_index)
                REG_MAX_VELOCITY: r_max_velocity <= i_wr_data;
                REG_ACCEL_RATE:   r_accel_rate   <= n_rate;
                REG_DECEL_RATE:   r_decel_rate   <= n_rate;
                default: ;
            endcase
        end
    end

    assign o_cfg.max_velocity = r_max_velocity;
    assign o_cfg.accel_rate   = r_accel_rate;
    assign o_cfg.decel_rate   = r_decel_rate;

endmodule

@@ sv/tsp_core.sv @@
// ----------------------------------------------------------------------------
// tsp_core
// Motion state and the single-pass command logic: phase, speed, position
// and remaining distance are updated once per executed transaction.
// ----------------------------------------------------------------------------
module tsp_core #(
    parameter int FRAC_BITS = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsp_pkg::t_cfg      i_cfg,
    input  logic               i_exec,
    input  logic [2:0]         i_cmd,
    input  logic signed [31:0] i_operand,
    output tsp_pkg::t_result   o_result
);
    import tsp_pkg::*;

    // Velocity run bound in whole steps per tick
    localparam int VEL_CAP = (32'h7FFF_FFFF >> FRAC_BITS) < 65535 ?
                             (32'h7FFF_FFFF >> FRAC_BITS) : 65535;
    localparam logic signed [31:0] VEL_MAX = 32'(VEL_CAP);

    t_phase             r_phase,  n_phase;
    logic signed [31:0] r_pos,    n_pos;
    logic signed [31:0] r_dist,   n_dist;
    logic signed [31:0] r_speed,  n_speed;
    logic signed [31:0] delta;

    // Move tick datapath
    logic [32:0]        acc_sum;
    logic               acc_sat;
    logic signed [33:0] dec_diff;
    logic               dec_zero;
    logic [32:0]        dist_mag;
    logic               cruise_end;
    t_phase             mt_phase;
    logic signed [31:0] mt_speed;
    logic [31:0]        mt_int;
    logic [31:0]        mt_mag;
    logic               mt_clip;
    logic signed [31:0] mt_delta;
    logic signed [31:0] mt_dist;

    // Velocity run and move target
    logic signed [31:0] vel_clamped;
    logic signed [31:0] target;

    // Ramp arithmetic on the held speed
    assign acc_sum  = {1'b0, r_speed} + {2'b00, i_cfg.accel_rate};
    assign acc_sat  = acc_sum >= {2'b00, i_cfg.max_velocity};
    assign dec_diff = {{2{r_speed[31]}}, r_speed} - {3'b000, i_cfg.decel_rate};
    assign dec_zero = dec_diff[33] || (dec_diff == '0);

    // Magnitude of the remaining distance, exact for the most negative value
    assign dist_mag   = r_dist[31] ? (33'd0 - {1'b1, r_dist}) : {1'b0, r_dist};
    assign cruise_end = dist_mag <= {1'b0, ($unsigned(r_speed) >> FRAC_BITS)};

    // Advance the ramp phase
    always_comb begin
        mt_phase = t_phase'(r_phase);
        mt_speed = r_speed;
        case (r_phase)
            PH_ACCEL: begin
                mt_speed = acc_sat ? {1'b0, i_cfg.max_velocity} : acc_sum[31:0];
                mt_phase = acc_sat ? PH_CRUISE : PH_ACCEL;
            end
            PH_CRUISE: begin
                mt_phase = cruise_end ? PH_DECEL : PH_CRUISE;
            end
            PH_DECEL: begin
                mt_speed = dec_zero ? '0 : dec_diff[31:0];
            end
            default: begin
                mt_speed = dec_zero ? '0 : dec_diff[31:0];
                mt_phase = dec_zero ? PH_IDLE : PH_STOP;
            end
        endcase
    end

    // Step size: whole speed, at least one while moving, clipped to distance
    assign mt_int   = $unsigned(mt_speed) >> FRAC_BITS;
    assign mt_mag   = (mt_int != '0) ? mt_int :
                      {31'd0, (mt_speed != '0) || (r_dist != '0)};
    assign mt_clip  = {1'b0, mt_mag} > dist_mag;
    assign mt_delta = mt_clip ? r_dist : (r_dist[31] ? -$signed(mt_mag) : $signed(mt_mag));
    assign mt_dist  = r_dist - mt_delta;

    // Saturate the velocity run operand
    assign vel_clamped = (i_operand > VEL_MAX)  ? VEL_MAX :
                         (i_operand < -VEL_MAX) ? -VEL_MAX : i_operand;
    assign target      = (i_cmd == CMD_MOVE_ABS) ? i_operand : r_pos + i_operand;

    // Decode the command and form the next state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_dist  = r_dist;
        n_speed = r_speed;
        delta   = '0;
        case (t_cmd'(i_cmd))
            CMD_TICK: begin
                if (r_phase == PH_VEL) begin
                    delta = r_speed >>> FRAC_BITS;
                    n_pos = r_pos + delta;
                end else if (r_phase != PH_IDLE) begin
                    delta   = mt_delta;
                    n_pos   = r_pos + mt_delta;
                    n_dist  = mt_dist;
                    n_speed = mt_speed;
                    n_phase = mt_phase;
                    if (mt_dist == '0) begin
                        n_phase = PH_IDLE;
                        n_speed = '0;
                    end
                end
            end
            CMD_MOVE_ABS, CMD_MOVE_REL: begin
                n_dist  = target - r_pos;
                n_speed = '0;
                n_phase = PH_ACCEL;
            end
            CMD_VEL_RUN: begin
                n_speed = vel_clamped <<< FRAC_BITS;
                n_phase = PH_VEL;
            end
            CMD_STOP: begin
                n_phase = PH_STOP;
            end
            default: ;
        endcase
    end

    // Hold the motion state; update on each executed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_dist  <= '0;
            r_speed <= '0;
        end else if (i_exec) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_dist  <= n_dist;
            r_speed <= n_speed;
        end
    end

    assign o_result.step_delta = delta;
    assign o_result.position   = n_pos;
    assign o_result.busy_res   = (n_phase != PH_IDLE);
    assign o_result.phase      = n_phase;

endmodule

@@ sv/trapezoidal_step_profile.sv @@
// ----------------------------------------------------------------------------
// trapezoidal_step_profile
// Stepper move generator with trapezoidal ramps and constant-velocity runs.
// ----------------------------------------------------------------------------
// Each command transaction (tick, absolute move, relative move, velocity
// run, stop) yields exactly one result transaction holding the step delta
// for that tick, the resulting position, a busy flag and the motion phase.
// Commands are taken one per clock while the result side keeps up: a
// transaction waits in the input register until it executes, the command
// logic and motion state update when it executes, and the result waits in
// the output register until taken. Velocities and rates are fixed point
// steps per tick with FRAC_BITS fraction bits; rates written as zero act
// as one. Write configuration only while no command is in flight.
// ----------------------------------------------------------------------------
module trapezoidal_step_profile #(
    parameter int FRAC_BITS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] operand (signed)
    input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [31:0] step_delta, [63:32] position,
                                        // [64] busy_res, [67:65] phase, [71:68] zero
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data
);
    import tsp_pkg::*;

    t_cfg               cfg;
    t_result            result;
    logic               r_in_valid;
    logic [2:0]         r_cmd;
    logic signed [31:0] r_operand;
    logic               r_out_valid;
    t_result            r_out;
    logic               exec;

    // Execute when a command is held and the result slot is free
    assign exec          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || exec;
    assign o_cfg_ready   = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_cmd     <= s_axis_tuser;
            r_operand <= s_axis_tdata;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out <= result;
        end
    end

    tsp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    tsp_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_exec    (exec),
        .i_cmd     (r_cmd),
        .i_operand (r_operand),
        .o_result  (result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.phase, r_out.busy_res,
                            r_out.position, r_out.step_delta};

endmodule
